FILE: rtl/cte_pkg.sv
// Shared types and constants for the connection table.
package cte_pkg;

   localparam int KEY_W       = 64;
   localparam int V4_ADDR_W   = 32;
   localparam int V6_ADDR_W   = 48;
   localparam int SLOT_W      = 4;
   localparam int FPOS_W      = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETHTYPE_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP    = 8'd6;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_APPEND = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MATCH,
      BK_RESOLVE
   } bk_state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic        is_ipv6;
      logic [47:0] src_addr;
      logic [15:0] src_port;
      logic [15:0] eth_type;
      logic [7:0]  ip_protocol;
      logic [3:0]  slot_select;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [FPOS_W-1:0] frame_position;
      logic              tcp_mark;
   } rsp_type;

   // Classified command as handed from the front end to the table engine.
   typedef struct packed {
      cmd_type           cmd;
      logic [KEY_W-1:0]  key;
      logic              tcp;
      logic [SLOT_W-1:0] slot_sel;
   } item_type;

endpackage

FILE: rtl/connection_table_round_robin_top.sv
// Path from request to response: front register, queue, compare state, resolve state.
// The engine takes one transaction at a time; the next is popped as the last one resolves.
// Response stalls back up through the two-entry queue to req_stall.
// Reset: synchronous, active high; clears TCP marks, frame positions, the insert pointer
// and the per-slot key valid bits, so all keys read as zero without a clearing pass.
module connection_table_round_robin_top #(
   parameter int TABLE_ENTRIES    = 16,
   parameter int FRAMES_PER_ENTRY = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cte_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cte_pkg::rsp_type rsp_data
);

   // Front end -> queue
   logic              push;
   cte_pkg::item_type push_data;
   logic              queue_full;

   // Queue -> table engine
   logic              pop;
   logic              not_empty;
   cte_pkg::item_type head;

   // Front end: builds the 64-bit key (v4: port above 32 address bits,
   // v6: port above 48 address bits), does the TCP test and reduces
   // slot_select modulo the table size.
   cte_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // Decouples the front end from the engine so either side can stall.
   cte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (not_empty),
      .head      (head)
   );

   // Engine: one transaction at a time. The compare cycle registers a
   // match bit per slot; the resolve cycle picks the lowest match, applies
   // add/append updates and loads the response register.
   cte_back #(
      .TABLE_ENTRIES   (TABLE_ENTRIES),
      .FRAMES_PER_ENTRY(FRAMES_PER_ENTRY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/cte_front.sv
// Front end: accepts requests, builds the key, runs the TCP test, reduces the slot.
module cte_front #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cte_pkg::req_type  req_data,
   output logic              push,
   output cte_pkg::item_type push_data,
   input  logic              queue_full
);

   logic              valid_ff, valid_in;
   cte_pkg::item_type item_ff, item_in;
   logic              load;

   always_comb begin
      item_in.cmd = req_data.cmd;
      if (req_data.is_ipv6) begin
         item_in.key = {req_data.src_port, req_data.src_addr[cte_pkg::V6_ADDR_W-1:0]};
      end else begin
         item_in.key = {16'h0000, req_data.src_port,
                        req_data.src_addr[cte_pkg::V4_ADDR_W-1:0]};
      end
      item_in.tcp = ((req_data.eth_type == cte_pkg::ETHTYPE_IPV4) ||
                     (req_data.eth_type == cte_pkg::ETHTYPE_IPV6)) &&
                    (req_data.ip_protocol == cte_pkg::PROTO_TCP);
      // slot_select modulo table size, as a 16-entry constant table
      item_in.slot_sel = '0;
      for (int i = 0; i < 16; i++) begin
         if (req_data.slot_select == 4'(i)) begin
            item_in.slot_sel = cte_pkg::SLOT_W'(i % TABLE_ENTRIES);
         end
      end
   end

   assign push      = valid_ff && !queue_full;
   assign req_stall = valid_ff && queue_full;
   assign load      = req_valid && !req_stall;
   assign push_data = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

FILE: rtl/cte_queue.sv
// Two-entry queue between the front end and the table engine.
module cte_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cte_pkg::item_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output cte_pkg::item_type head
);

   localparam int PTR_W = $clog2(cte_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(cte_pkg::QUEUE_DEPTH + 1);

   cte_pkg::item_type  mem_ff [cte_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(cte_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      bump = (p == PTR_W'(cte_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/cte_back.sv
// Table engine: key compare, lowest-match encode, slot updates, result register.
module cte_back #(
   parameter int TABLE_ENTRIES    = 16,
   parameter int FRAMES_PER_ENTRY = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              not_empty,
   input  cte_pkg::item_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cte_pkg::rsp_type  rsp_data
);

   localparam int SW = $clog2(TABLE_ENTRIES);
   localparam int FW = $clog2(FRAMES_PER_ENTRY);

   cte_pkg::bk_state_type state_ff, state_in;
   cte_pkg::item_type     op_ff;
   logic [TABLE_ENTRIES-1:0] match_ff;

   logic [cte_pkg::KEY_W-1:0] key_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]  key_vld_ff;
   logic [TABLE_ENTRIES-1:0]  tcp_ff;
   logic [FW-1:0]             fpos_ff [TABLE_ENTRIES];
   logic [SW-1:0]             ptr_ff, ptr_in;

   logic             rsp_valid_ff, rsp_valid_in;
   cte_pkg::rsp_type rsp_ff, rsp_in;

   logic          out_free, fire;
   logic          hit_any;
   logic [SW-1:0] enc_slot;
   logic [SW+3:0] sel_ext;
   logic [SW-1:0] sel_idx;
   logic [SW-1:0] slot_idx;
   logic [FW-1:0] fpos_out;
   logic [SW+3:0] slot_ext;
   logic [FW+2:0] fpos_ext;
   logic          do_add, do_append;
   logic [SW-1:0] upd_idx;
   logic [FW-1:0] upd_pos;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = (state_ff == cte_pkg::BK_RESOLVE) && out_free;

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      unique case (state_ff)
         cte_pkg::BK_IDLE: begin
            if (not_empty) begin
               pop      = 1'b1;
               state_in = cte_pkg::BK_MATCH;
            end
         end
         cte_pkg::BK_MATCH: begin
            state_in = cte_pkg::BK_RESOLVE;
         end
         cte_pkg::BK_RESOLVE: begin
            if (out_free) begin
               pop      = not_empty;
               state_in = not_empty ? cte_pkg::BK_MATCH : cte_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = cte_pkg::BK_IDLE;
         end
      endcase
   end

   // lowest matching slot
   always_comb begin
      hit_any  = |match_ff;
      enc_slot = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            enc_slot = SW'(i);
         end
      end
   end

   assign sel_ext = {{SW{1'b0}}, op_ff.slot_sel};
   assign sel_idx = sel_ext[SW-1:0];

   always_comb begin
      rsp_in    = '0;
      slot_idx  = '0;
      fpos_out  = '0;
      do_add    = 1'b0;
      do_append = 1'b0;
      upd_idx   = sel_idx;
      upd_pos   = '0;
      case (op_ff.cmd)
         cte_pkg::CMD_LOOKUP: begin
            rsp_in.hit      = hit_any;
            slot_idx        = enc_slot;
            rsp_in.tcp_mark = tcp_ff[enc_slot];
         end
         cte_pkg::CMD_ADD: begin
            do_add          = 1'b1;
            slot_idx        = ptr_ff;
            upd_idx         = ptr_ff;
            upd_pos         = FW'(1);   // frame 0 appended
            rsp_in.tcp_mark = op_ff.tcp;
         end
         cte_pkg::CMD_APPEND: begin
            do_append       = 1'b1;
            slot_idx        = sel_idx;
            fpos_out        = fpos_ff[sel_idx];
            upd_pos         = (fpos_ff[sel_idx] == FW'(FRAMES_PER_ENTRY - 1)) ?
                              '0 : fpos_ff[sel_idx] + FW'(1);
            rsp_in.tcp_mark = tcp_ff[sel_idx];
         end
         default: begin
            rsp_in = '0;
         end
      endcase
      slot_ext              = {4'b0000, slot_idx};
      fpos_ext              = {3'b000, fpos_out};
      rsp_in.slot           = slot_ext[cte_pkg::SLOT_W-1:0];
      rsp_in.frame_position = fpos_ext[cte_pkg::FPOS_W-1:0];
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (fire && do_add) begin
         ptr_in = (ptr_ff == SW'(TABLE_ENTRIES - 1)) ? '0 : ptr_ff + SW'(1);
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cte_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         key_vld_ff   <= '0;
         tcp_ff       <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            fpos_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         if (fire && do_add) begin
            key_vld_ff[upd_idx] <= 1'b1;
            tcp_ff[upd_idx]     <= op_ff.tcp;
         end
         if (fire && (do_add || do_append)) begin
            fpos_ff[upd_idx] <= upd_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff <= head;
      end
      if (fire && do_add) begin
         key_ff[upd_idx] <= op_ff.key;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // per-slot compare; a never-written slot matches key zero
   always_ff @(posedge clock) begin
      if (state_ff == cte_pkg::BK_MATCH) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match_ff[i] <= key_vld_ff[i] ? (key_ff[i] == op_ff.key) :
                                           (op_ff.key == '0);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
